// ===== hdl/hht_pkg.sv =====
// Shared types and constants for the hopscotch hash table.
// Used by the controller, the datapath and the top level; no dependencies.
package hht_pkg;

    // Default geometry handed to the top-level parameters.
    localparam int MAX_TABLE_LOG2_DEF = 12;
    localparam int HOP_RANGE_DEF      = 32;

    // Fixed field widths.
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 4;
    localparam int OP_W      = 2;
    localparam int DATA_W    = KEY_W + LEN_W + VAL_W;
    localparam int IN_TDATA_W = 136;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Controller states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PR_RD,
        ST_PR_CHK,
        ST_HOP_CHK,
        ST_HP_RD,
        ST_HP_CHK,
        ST_MV_WR,
        ST_MV_CLR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_LK_RD,
        ST_LK_MAP,
        ST_LK_SEL,
        ST_LK_CHK,
        ST_DEL_WR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic probe_rd;
        logic probe_inc;
        logic fb_load;
        logic hop_setup;
        logic hop_rd_mv;
        logic hop_adv;
        logic hop_move;
        logic mv_wr;
        logic mv_clr;
        logic fin_wr;
        logic lk_cap;
        logic lk_sel;
        logic del_wr;
        logic res_fail;
        logic res_ok;
        logic res_found;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] in_op;
        logic [OP_W-1:0] req_op;
        logic            clr_last;
        logic            probe_ge;
        logic            probe_valid;
        logic            dist_lt_h;
        logic            mfd_zero;
        logic            hop_found;
        logic            work_zero;
        logic            match;
        logic            out_free;
    } sts_t;

    // Byte mask that covers the first min(len, KEY_BYTES) key bytes.
    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        int               n;
        n = (int'(len) < KEY_BYTES) ? int'(len) : KEY_BYTES;
        for (int b = 0; b < KEY_W / 8; b++)
        begin
            m[8*b +: 8] = (b < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== hdl/hht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/hht_ctrl.sv =====
// Controller state machine of the hopscotch hash table.
// Depends on hht_pkg for the state, command and status types.
module hht_ctrl
    import hht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    case (sts.in_op)
                        OP_INSERT: state_next = ST_PR_RD;
                        OP_FIND:   state_next = ST_LK_RD;
                        OP_DELETE: state_next = ST_LK_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_PR_RD:   state_next = sts.probe_ge ? ST_DONE : ST_PR_CHK;
            ST_PR_CHK:  state_next = sts.probe_valid ? ST_PR_RD : ST_HOP_CHK;
            ST_HOP_CHK: state_next = sts.dist_lt_h ? ST_FIN_RD : ST_HP_RD;
            ST_HP_RD:   state_next = sts.mfd_zero ? ST_DONE : ST_HP_CHK;
            ST_HP_CHK:  state_next = sts.hop_found ? ST_MV_WR : ST_HP_RD;
            ST_MV_WR:   state_next = ST_MV_CLR;
            ST_MV_CLR:  state_next = ST_HOP_CHK;
            ST_FIN_RD:  state_next = ST_FIN_WR;
            ST_FIN_WR:  state_next = ST_DONE;
            ST_LK_RD:   state_next = ST_LK_MAP;
            ST_LK_MAP:  state_next = ST_LK_SEL;
            ST_LK_SEL:  state_next = sts.work_zero ? ST_DONE : ST_LK_CHK;
            ST_LK_CHK:
            begin
                if (!sts.match)
                begin
                    state_next = ST_LK_SEL;
                end
                else if (sts.req_op == OP_DELETE)
                begin
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DEL_WR:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:   cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid && sts.in_op != OP_INSERT && sts.in_op != OP_FIND &&
                    sts.in_op != OP_DELETE)
                begin
                    cmd.res_fail = 1'b1;
                end
            end
            ST_PR_RD:
            begin
                cmd.probe_rd = 1'b1;
                cmd.res_fail = sts.probe_ge;
            end
            ST_PR_CHK:
            begin
                cmd.probe_inc = sts.probe_valid;
                cmd.fb_load   = !sts.probe_valid;
            end
            ST_HOP_CHK: cmd.hop_setup = !sts.dist_lt_h;
            ST_HP_RD:
            begin
                cmd.hop_rd_mv = 1'b1;
                cmd.res_fail  = sts.mfd_zero;
            end
            ST_HP_CHK:
            begin
                cmd.hop_move = sts.hop_found;
                cmd.hop_adv  = !sts.hop_found;
            end
            ST_MV_WR:   cmd.mv_wr = 1'b1;
            ST_MV_CLR:  cmd.mv_clr = 1'b1;
            ST_FIN_WR:
            begin
                cmd.fin_wr = 1'b1;
                cmd.res_ok = 1'b1;
            end
            ST_LK_MAP:  cmd.lk_cap = 1'b1;
            ST_LK_SEL:
            begin
                cmd.lk_sel   = !sts.work_zero;
                cmd.res_fail = sts.work_zero;
            end
            ST_LK_CHK:  cmd.res_found = sts.match && (sts.req_op == OP_FIND);
            ST_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
                cmd.res_ok = 1'b1;
            end
            ST_DONE:    cmd.out_load = sts.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

// ===== hdl/hht_dp.sv =====
// Datapath of the hopscotch hash table: request registers, bucket stores,
// probe and hop arithmetic, result and output registers. Uses hht_pkg and hht_ram.
module hht_dp
    import hht_pkg::*;
#(
    parameter int MAX_TABLE_LOG2 = MAX_TABLE_LOG2_DEF,
    parameter int HOP_RANGE      = HOP_RANGE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VAL_W-1:0]      m_tdata,
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int AW    = MAX_TABLE_LOG2;
    localparam int LW    = AW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int HW    = $clog2(HOP_RANGE);

    // Lowest set bit of a neighborhood bitmap.
    function automatic logic [HW-1:0] lowest(input logic [HOP_RANGE-1:0] v);
        logic [HW-1:0] r;
        r = '0;
        for (int i = HOP_RANGE - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = HW'(i);
            end
        end
        return r;
    endfunction

    // Registers.
    logic [CFG_W-1:0]     cfg_reg;
    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [AW-1:0]        home_reg;
    logic [LW-1:0]        probe_reg;
    logic [LW-1:0]        fb_reg;
    logic [LW-1:0]        mv_reg;
    logic [HW-1:0]        mfd_reg;
    logic [LW-1:0]        src_reg;
    logic [HOP_RANGE-1:0] work_reg;
    logic [HOP_RANGE-1:0] hbits_reg;
    logic [HW-1:0]        bit_reg;
    logic [AW-1:0]        slot_reg;
    logic [AW-1:0]        clr_reg;
    logic                 res_status_reg;
    logic [VAL_W-1:0]     res_value_reg;
    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic [VAL_W-1:0]     out_value_reg;

    // Store read data.
    logic                 valid_rdata;
    logic [HOP_RANGE-1:0] hop_rdata;
    logic [DATA_W-1:0]    data_rdata;

    // Combinational helpers.
    logic [AW-1:0]        size_mask;
    logic [LW-1:0]        size;
    logic [AW-1:0]        in_home;
    logic [LW-1:0]        fb_dist;
    logic [HOP_RANGE-1:0] low_mask;
    logic [HOP_RANGE-1:0] hop_cand;
    logic [HW-1:0]        hop_bit;
    logic [LW-1:0]        src_next;
    logic [HOP_RANGE-1:0] hop_moved;
    logic [HW-1:0]        work_bit;
    logic [AW-1:0]        lk_slot;
    logic                 in_accept;

    // Store ports.
    logic                 valid_we;
    logic [AW-1:0]        valid_waddr;
    logic                 valid_wdata;
    logic [AW-1:0]        valid_raddr;
    logic                 hop_we;
    logic [AW-1:0]        hop_waddr;
    logic [HOP_RANGE-1:0] hop_wdata;
    logic [AW-1:0]        hop_raddr;
    logic                 data_we;
    logic [AW-1:0]        data_waddr;
    logic [DATA_W-1:0]    data_wdata;
    logic [AW-1:0]        data_raddr;

    // Table size in use; values above the store depth saturate naturally.
    always_comb
    begin
        for (int j = 0; j < AW; j++)
        begin
            size_mask[j] = (j < int'(cfg_reg));
        end
    end
    assign size = {1'b0, size_mask} + LW'(1);

    assign in_accept = s_tvalid && cmd.in_ready;
    assign in_home   = s_tdata[AW-1:0] & size_mask;
    assign fb_dist   = fb_reg - {1'b0, home_reg};

    // Candidate search below the current hop distance.
    always_comb
    begin
        for (int j = 0; j < HOP_RANGE; j++)
        begin
            low_mask[j] = (j < int'(mfd_reg));
        end
    end
    assign hop_cand  = hop_rdata & low_mask;
    assign hop_bit   = lowest(hop_cand);
    assign src_next  = mv_reg + LW'(hop_bit);
    assign hop_moved = (hop_rdata | (HOP_RANGE'(1) << mfd_reg)) & ~(HOP_RANGE'(1) << hop_bit);

    // Lookup scan picks the next neighborhood member.
    assign work_bit = lowest(work_reg);
    assign lk_slot  = home_reg + AW'(work_bit);

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            cfg_reg <= cfg_data;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // Request capture on an accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[32 +: KEY_W];
            len_reg  <= s_tdata[96 +: LEN_W];
            val_reg  <= s_tdata[100 +: VAL_W];
            home_reg <= in_home;
        end
    end

    // Probe, hop and lookup working registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            probe_reg <= {1'b0, in_home};
        end
        else if (cmd.probe_inc)
        begin
            probe_reg <= probe_reg + LW'(1);
        end

        if (cmd.fb_load)
        begin
            fb_reg <= probe_reg;
        end
        else if (cmd.mv_clr)
        begin
            fb_reg <= src_reg;
        end

        if (cmd.hop_setup)
        begin
            mv_reg  <= fb_reg - LW'(HOP_RANGE - 1);
            mfd_reg <= HW'(HOP_RANGE - 1);
        end
        else if (cmd.hop_adv)
        begin
            mv_reg  <= mv_reg + LW'(1);
            mfd_reg <= mfd_reg - HW'(1);
        end

        if (cmd.hop_move)
        begin
            src_reg <= src_next;
        end

        if (cmd.lk_cap)
        begin
            work_reg  <= hop_rdata;
            hbits_reg <= hop_rdata;
        end
        else if (cmd.lk_sel)
        begin
            work_reg <= work_reg & ~(HOP_RANGE'(1) << work_bit);
            bit_reg  <= work_bit;
            slot_reg <= lk_slot;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.res_fail)
        begin
            res_status_reg <= 1'b1;
            res_value_reg  <= '0;
        end
        else if (cmd.res_ok)
        begin
            res_status_reg <= 1'b0;
            res_value_reg  <= '0;
        end
        else if (cmd.res_found)
        begin
            res_status_reg <= 1'b0;
            res_value_reg  <= data_rdata[KEY_W + LEN_W +: VAL_W];
        end
    end

    // Output register: holds a beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    // Valid store port selection.
    always_comb
    begin
        valid_we    = cmd.clr_wr | cmd.mv_wr | cmd.mv_clr | cmd.fin_wr | cmd.del_wr;
        valid_wdata = cmd.mv_wr | cmd.fin_wr;
        if (cmd.clr_wr)
        begin
            valid_waddr = clr_reg;
        end
        else if (cmd.mv_clr)
        begin
            valid_waddr = src_reg[AW-1:0];
        end
        else if (cmd.del_wr)
        begin
            valid_waddr = slot_reg;
        end
        else
        begin
            valid_waddr = fb_reg[AW-1:0];
        end
        valid_raddr = cmd.probe_rd ? probe_reg[AW-1:0] : lk_slot;
    end

    // Hop bitmap store port selection.
    always_comb
    begin
        hop_we = cmd.clr_wr | cmd.hop_move | cmd.fin_wr | cmd.del_wr;
        if (cmd.clr_wr)
        begin
            hop_waddr = clr_reg;
            hop_wdata = '0;
        end
        else if (cmd.hop_move)
        begin
            hop_waddr = mv_reg[AW-1:0];
            hop_wdata = hop_moved;
        end
        else if (cmd.del_wr)
        begin
            hop_waddr = home_reg;
            hop_wdata = hbits_reg & ~(HOP_RANGE'(1) << bit_reg);
        end
        else
        begin
            hop_waddr = home_reg;
            hop_wdata = hop_rdata | (HOP_RANGE'(1) << fb_dist[HW-1:0]);
        end
        hop_raddr = cmd.hop_rd_mv ? mv_reg[AW-1:0] : home_reg;
    end

    // Entry data store port selection.
    always_comb
    begin
        data_we    = cmd.mv_wr | cmd.fin_wr;
        data_waddr = fb_reg[AW-1:0];
        if (cmd.mv_wr)
        begin
            data_wdata = data_rdata;
        end
        else
        begin
            data_wdata = {val_reg, len_reg, key_reg & key_mask(len_reg)};
        end
        data_raddr = cmd.hop_move ? src_next[AW-1:0] : lk_slot;
    end

    hht_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid_ram (
        .clk   (clk),
        .we    (valid_we),
        .waddr (valid_waddr),
        .wdata (valid_wdata),
        .raddr (valid_raddr),
        .rdata (valid_rdata)
    );

    hht_ram #(.WIDTH(HOP_RANGE), .DEPTH(DEPTH)) u_hop_ram (
        .clk   (clk),
        .we    (hop_we),
        .waddr (hop_waddr),
        .wdata (hop_wdata),
        .raddr (hop_raddr),
        .rdata (hop_rdata)
    );

    hht_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    // Status back to the controller.
    always_comb
    begin
        sts.in_valid    = s_tvalid;
        sts.in_op       = s_tuser;
        sts.req_op      = op_reg;
        sts.clr_last    = (clr_reg == {AW{1'b1}});
        sts.probe_ge    = (probe_reg >= size);
        sts.probe_valid = valid_rdata;
        sts.dist_lt_h   = (fb_dist < LW'(HOP_RANGE));
        sts.mfd_zero    = (mfd_reg == '0);
        sts.hop_found   = |hop_cand;
        sts.work_zero   = (work_reg == '0);
        sts.match       = valid_rdata && (data_rdata[KEY_W +: LEN_W] == len_reg) &&
                          (((data_rdata[KEY_W-1:0] ^ key_reg) & key_mask(len_reg)) == '0);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    assign s_tready = cmd.in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== hdl/hopscotch_hash_table.sv =====
// Hopscotch hash table, one request at a time. Find and delete read the home hop bitmap and
// check each set bit in turn, with a closing step on a miss or a delete hit; insert probes
// buckets, tries neighborhood buckets while hopping, displaces entries and then finishes,
// each step one access of a registered-read store. The next beat can be taken in the cycle
// after the result is loaded. After reset all 2^MAX_TABLE_LOG2 (4096 by default) entries of
// the valid and hop stores are cleared with s_tready low; config is taken throughout.
module hopscotch_hash_table
    import hht_pkg::*;
#(
    parameter int MAX_TABLE_LOG2 = MAX_TABLE_LOG2_DEF,
    parameter int HOP_RANGE      = HOP_RANGE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // hash[31:0], key[95:32], key_len[99:96], value_handle[131:100], zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // value_out[31:0]
    output logic [VAL_W-1:0]      m_tdata,
    // status[0]
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    hht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Stores and arithmetic.
    hht_dp #(
        .MAX_TABLE_LOG2 (MAX_TABLE_LOG2),
        .HOP_RANGE      (HOP_RANGE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== test/hht_checker.sv =====
// Scoreboard for the hopscotch hash table: watches the request, result and
// configuration channels, predicts each result and compares. Depends on hht_pkg.
module hht_checker
    import hht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [VAL_W-1:0]      m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    fails,
    output int                    pending
);

    localparam int DEPTH  = 4096;
    localparam int IMASK  = DEPTH - 1;
    localparam int NEIGH  = 32;
    localparam int LOG2_MAX = 12;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] value;
    } lookup_result_t;

    // Shadow copy of the table.
    bit               occ [DEPTH];
    logic [KEY_W-1:0] skey [DEPTH];
    logic [LEN_W-1:0] slen [DEPTH];
    logic [VAL_W-1:0] sval [DEPTH];
    logic [31:0]      hops [DEPTH];
    logic [CFG_W-1:0] size_log2;

    lookup_result_t expected_results[$];

    function automatic logic [KEY_W-1:0] len_mask(logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < len)
                m[8*b +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic int buckets_in_use();
        return 1 << ((size_log2 > LOG2_MAX) ? LOG2_MAX : size_log2);
    endfunction

    // Returns the neighborhood offset of a matching entry, or -1.
    function automatic int locate(int home, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
        logic [31:0] bits;
        int          s;
        bits = hops[home & IMASK];
        for (int i = 0; i < NEIGH; i++)
        begin
            s = (home + i) & IMASK;
            if (bits[i] && occ[s] && slen[s] == len && ((skey[s] ^ key) & len_mask(len)) == 0)
                return i;
        end
        return -1;
    endfunction

    function automatic void relocate(int dst, int src);
        dst = dst & IMASK;
        src = src & IMASK;
        skey[dst] = skey[src];
        slen[dst] = slen[src];
        sval[dst] = sval[src];
        occ[dst]  = 1'b1;
        occ[src]  = 1'b0;
    endfunction

    // Probe for a free bucket, hop it into the neighborhood, then store.
    function automatic bit place_entry(int home, logic [KEY_W-1:0] key,
                                       logic [LEN_W-1:0] len, logic [VAL_W-1:0] val);
        int          size;
        int          gap;
        int          fb;
        int          mv;
        int          mfd;
        logic [31:0] bits;
        bit          moved;
        size = buckets_in_use();
        gap = 0;
        while (home + gap < size && occ[(home + gap) & IMASK])
            gap++;
        if (home + gap >= size)
            return 1'b0;
        fb = home + gap;
        while (gap >= NEIGH)
        begin
            mv = fb - (NEIGH - 1);
            mfd = NEIGH - 1;
            moved = 1'b0;
            while (mfd > 0 && !moved)
            begin
                bits = hops[mv & IMASK];
                for (int i = 0; i < mfd; i++)
                begin
                    if (bits[i])
                    begin
                        relocate(fb, mv + i);
                        bits[mfd] = 1'b1;
                        bits[i] = 1'b0;
                        hops[mv & IMASK] = bits;
                        fb = mv + i;
                        gap -= mfd - i;
                        moved = 1'b1;
                        break;
                    end
                end
                mfd--;
                mv++;
            end
            if (!moved)
                return 1'b0;
        end
        fb = fb & IMASK;
        skey[fb] = key & len_mask(len);
        slen[fb] = len;
        sval[fb] = val;
        occ[fb] = 1'b1;
        hops[home & IMASK][gap] = 1'b1;
        return 1'b1;
    endfunction

    function automatic lookup_result_t apply_request(logic [OP_W-1:0] op,
                                                     logic [IN_TDATA_W-1:0] d);
        lookup_result_t r;
        int             home;
        int             hit;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        key = d[95:32];
        len = d[99:96];
        home = d[31:0] & (buckets_in_use() - 1);
        r.status = 1'b1;
        r.value = '0;
        case (op)
            OP_INSERT: r.status = place_entry(home, key, len, d[131:100]) ? 1'b0 : 1'b1;
            OP_FIND:
            begin
                hit = locate(home, key, len);
                if (hit >= 0)
                begin
                    r.status = 1'b0;
                    r.value = sval[(home + hit) & IMASK];
                end
            end
            OP_DELETE:
            begin
                hit = locate(home, key, len);
                if (hit >= 0)
                begin
                    hops[home & IMASK][hit] = 1'b0;
                    occ[(home + hit) & IMASK] = 1'b0;
                    r.status = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Results are compared before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                occ[i] = 1'b0;
                hops[i] = '0;
            end
            size_log2 = CFG_RESET;
            fails = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("result beat with nothing expected: status %0d value %h",
                                 m_tuser, m_tdata);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.status !== m_tuser || exp_r.value !== m_tdata)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected status %0d value %h, got %0d %h",
                                     exp_r.status, exp_r.value, m_tuser, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata));
            if (cfg_valid && cfg_ready)
                size_log2 = cfg_data;
            pending = expected_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the hopscotch hash table testbench: clock, reset, request and
// configuration stimulus, verdict. Depends on hht_pkg, hht_checker and the RTL.
module tb_top;
    import hht_pkg::*;

    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [31:0]      hash;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } stored_key_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [VAL_W-1:0]      m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    int                    fails;
    int                    pending;
    bit                    calm;
    int                    cur_log2;
    int                    quiet_cycles;
    stored_key_t           key_pool[$];

    hopscotch_hash_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hht_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side backpressure.
    initial m_tready = 1'b0;
    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 21);

    // Watchdog over cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [31:0] hash,
                                logic [KEY_W-1:0] key, logic [LEN_W-1:0] len,
                                logic [VAL_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, val, len, key, hash};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Writes the table size once every outstanding result has come back.
    task automatic set_table_log2(int lg);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(lg);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_log2 = lg;
    endtask

    task automatic random_request();
        int          size;
        int          home;
        int          pick;
        int          r;
        logic [31:0] hash;
        stored_key_t k;
        size = 1 << ((cur_log2 > 12) ? 12 : cur_log2);
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            // Clustered homes force long probes and hopping.
            pick = $urandom_range(0, 9);
            if (pick < 7)
                home = $urandom_range(0, (size > 8) ? 7 : size - 1);
            else if (pick < 8)
                home = size - 1 - $urandom_range(0, (size > 4) ? 3 : size - 1);
            else
                home = $urandom_range(0, size - 1);
            hash = ($urandom & ~(size - 1)) | home;
            k.hash = hash;
            k.key = {$urandom, $urandom};
            k.len = LEN_W'($urandom_range(1, 8));
            if (key_pool.size() < 200)
                key_pool.push_back(k);
            send_request(OP_INSERT, hash, k.key, k.len, $urandom);
        end
        else if (r < 92 && key_pool.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            pick = $urandom_range(0, key_pool.size() - 1);
            k = key_pool[pick];
            if (r < 75)
                send_request(OP_FIND, k.hash, k.key, k.len, $urandom);
            else
            begin
                key_pool.delete(pick);
                send_request(OP_DELETE, k.hash, k.key, k.len, $urandom);
            end
        end
        else
            send_request(OP_W'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                         LEN_W'($urandom_range(0, 15)), $urandom);
    endtask

    initial
    begin
        int settings[7];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        cfg_valid = 1'b0;
        cfg_data = CFG_RESET;
        calm = 1'b0;
        cur_log2 = 12;
        quiet_cycles = 0;
        settings = '{7, 5, 6, 3, 0, 13, 12};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with an oversized table setting, used as the maximum.
        set_table_log2(15);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
        send_request(OP_FIND, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_request(OP_FIND, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 64'h1234, 4'd2, 32'h5);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_request(OP_INSERT, 32'h0, 64'h0, 4'd1, 32'h0);
        send_request(OP_INSERT, 32'h0, 64'h0, 4'd1, 32'hA5A5_A5A5);
        send_request(OP_FIND, 32'h0, 64'hFF00, 4'd1, 32'h0);
        send_request(OP_INSERT, 32'h10, 64'hDEAD, 4'd0, 32'h77);
        send_request(OP_FIND, 32'h10, 64'hBEEF, 4'd0, 32'h0);
        send_request(OP_INSERT, 32'h20, 64'h8877_6655_4433_2211, 4'd15, 32'h99);
        send_request(OP_FIND, 32'h20, 64'h8877_6655_4433_2211, 4'd15, 32'h0);
        send_request(OP_FIND, 32'h20, 64'h8877_6655_4433_2211, 4'd8, 32'h0);
        send_request(2'd3, 32'h20, 64'h8877_6655_4433_2211, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0, 64'h0, 4'd1, 32'h0);
        send_request(OP_FIND, 32'h0, 64'h0, 4'd1, 32'h0);
        send_request(OP_FIND, 32'h5555_5555, 64'h5555_5555_5555_5555, 4'd4, 32'h0);

        // Random phases, one per table size; one phase runs without idling.
        foreach (settings[p])
        begin
            set_table_log2(settings[p]);
            key_pool.delete();
            calm = (p == 2);
            repeat (250)
                random_request();
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
